/* rtl/core/srd_pkg.sv */
// Shared constants for the sun right-ascension / declination core.
// Turn-rate and offset constants, CORDIC angle table and fixed-point limits.
// No dependencies.
`default_nettype none

package srd_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int MAX_STEPS        = 32;
  // CORDIC datapath width: Q30 values plus headroom for gain and pi offset
  localparam int CW               = 36;

  // Truncated binary fraction num/den (num < den), 64 fraction bits
  function automatic logic [63:0] frac64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int i = 0; i < 64; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Offsets and daily rates in turns, 64 fraction bits
  localparam logic [63:0] L_OFF  = frac64(64'd280460, 64'd360000);
  localparam logic [63:0] L_RATE = frac64(64'd9856474, 64'd3600000000);
  localparam logic [63:0] G_OFF  = frac64(64'd357528, 64'd360000);
  localparam logic [63:0] G_RATE = frac64(64'd9856003, 64'd3600000000);
  localparam logic [63:0] E_OFF  = frac64(64'd23439, 64'd360000);
  localparam logic [63:0] E_RATE = frac64(64'd4, 64'd3600000000);

  // Equation-of-center amplitudes in turns, 32 fraction bits
  localparam logic [31:0] A1_TURN = 32'(frac64(64'd1915, 64'd360000) >> 32);
  localparam logic [31:0] A2_TURN = 32'(frac64(64'd20, 64'd360000) >> 32);

  // J2000 epoch in days, 32 fraction bits
  localparam logic [55:0] J2000_FX = 56'd2451545 << 32;

  localparam logic signed [CW-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic signed [CW-1:0] GAIN_Q30  = 36'sh026DD3B6A;
  localparam logic signed [31:0]   OUT_LIMIT = 32'sd1686629713;

  // atan(2^-i) in radians, Q30
  localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h00080000,
    32'h00040000, 32'h00020000, 32'h00010000, 32'h00008000, 32'h00004000, 32'h00002000,
    32'h00001000, 32'h00000800, 32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080,
    32'h00000040, 32'h00000020, 32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

/* rtl/core/srd_cordic.sv */
// Pipelined CORDIC, one register stage per iteration, rotation or vectoring.
// A sideband word and a valid bit travel alongside each beat.
// Depends on srd_pkg (angle table, step limit).
`default_nettype none

module srd_cordic import srd_pkg::*; #(
  parameter int W         = CW,
  parameter int STEPS     = CORDIC_STEPS_DEF,
  parameter int MW        = 2,
  parameter bit VECTORING = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  logic signed [W-1:0] in_z,
  input  logic [MW-1:0]       in_meta,
  output logic                out_valid,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic signed [W-1:0] out_z,
  output logic [MW-1:0]       out_meta
);

  localparam int N = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

  logic signed [W-1:0] xr [1:N];
  logic signed [W-1:0] yr [1:N];
  logic signed [W-1:0] zr [1:N];
  logic [MW-1:0]       mr [1:N];
  logic                vr [1:N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [W-1:0] ANG = $signed(W'(ATAN_TAB[i]));
    logic signed [W-1:0] xc, yc, zc;
    logic [MW-1:0]       mc;
    logic                vc;
    logic                pos;

    if (i == 0) begin : g_first
      assign xc = in_x;
      assign yc = in_y;
      assign zc = in_z;
      assign mc = in_meta;
      assign vc = in_valid;
    end else begin : g_next
      assign xc = xr[i];
      assign yc = yr[i];
      assign zc = zr[i];
      assign mc = mr[i];
      assign vc = vr[i];
    end

    // pick the micro-rotation direction
    assign pos = VECTORING ? !(yc > 0) : (zc >= 0);

    // advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i+1] <= 1'b0;
      end else begin
        vr[i+1] <= vc;
      end
    end

    // rotate by atan(2^-i)
    always_ff @(posedge clk) begin
      xr[i+1] <= pos ? xc - (yc >>> i) : xc + (yc >>> i);
      yr[i+1] <= pos ? yc + (xc >>> i) : yc - (xc >>> i);
      zr[i+1] <= pos ? zc - ANG : zc + ANG;
      mr[i+1] <= mc;
    end
  end

  assign out_valid = vr[N];
  assign out_x     = xr[N];
  assign out_y     = yr[N];
  assign out_z     = zr[N];
  assign out_meta  = mr[N];

endmodule

`default_nettype wire

/* rtl/core/sun_ra_dec_position_core.sv */
// Sun right ascension and declination from a Julian date.
// Depends on srd_pkg and srd_cordic.
//
// Usage: drive julian_day (days, 32 fraction bits) and pulse start; a beat is
// taken at each rising edge with start high and busy low. busy stays low, so a
// new date can enter every cycle. Each beat yields one result: done is high for
// exactly one cycle with right_ascension and declination (radians, Q29 signed,
// saturated to about +-pi) on the ports; the receiver must take it then.
// Throughput is one date per cycle; the path is a straight pipeline of fixed
// stages: turn-angle multiply and sum, CORDICs for the mean anomaly and its
// double, CORDICs for ecliptic longitude and obliquity, a 32-stage square
// root for the asin leg, and vectoring CORDICs for the two atan2 angles.
// CORDIC_STEPS above 32 runs 32 iterations.
// Reset clears every valid bit in flight; no result follows a beat that was in
// the pipeline during reset.
`default_nettype none

module sun_ra_dec_position_core import srd_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [53:0]        julian_day,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] right_ascension,
  output logic signed [31:0] declination
);

  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int LAT   = 3 * NSTEP + 44;
  localparam logic signed [32:0] PI33 = 33'sd3373259426;
  localparam logic [63:0] RATE [3] = '{L_RATE, G_RATE, E_RATE};
  localparam logic [63:0] OFF  [3] = '{L_OFF, G_OFF, E_OFF};

  typedef struct packed {
    logic signed [31:0] co;
    logic signed [31:0] si;
  } sc_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] base;
    logic                 zero;
  } at2_t;

  function automatic logic [1:0] turn_quadrant(input logic [31:0] a);
    logic [31:0] sh;
    sh = a + 32'h2000_0000;
    return sh[31:30];
  endfunction

  function automatic logic signed [30:0] turn_residual(input logic [31:0] a);
    logic [31:0] sh;
    sh = a + 32'h2000_0000;
    return $signed({1'b0, sh[29:0]}) - 31'sd536870912;
  endfunction

  // radians Q30 from residual*pi, rounded half up
  function automatic logic signed [CW-1:0] z_start(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd1073741824) >>> 31;
    return t[CW-1:0];
  endfunction

  function automatic sc_t quad_fold(input logic [1:0] q, input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
    logic signed [CW-1:0] co;
    logic signed [CW-1:0] si;
    case (q)
      2'd0:    begin co = x;  si = y;  end
      2'd1:    begin co = -y; si = x;  end
      2'd2:    begin co = -x; si = -y; end
      default: begin co = y;  si = -x; end
    endcase
    return '{co: co[31:0], si: si[31:0]};
  endfunction

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic at2_t at2_prep(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x);
    at2_t r;
    r.zero = (x == 0) && (y == 0);
    if (x < 0) begin
      r.base = (y >= 0) ? PI_Q30 : -PI_Q30;
      r.x    = -x;
      r.y    = -y;
    end else begin
      r.base = '0;
      r.x    = x;
      r.y    = y;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] out_angle(input logic zero,
                                                  input logic signed [CW-1:0] base,
                                                  input logic signed [CW-1:0] z);
    logic signed [CW-1:0] ang;
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] lim;
    lim = CW'(OUT_LIMIT);
    ang = zero ? '0 : base + z;
    v   = (ang + 1) >>> 1;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[31:0];
  endfunction

  assign busy = 1'b0;

  // ---------------- stage 0: input register
  logic        v_s0;
  logic [53:0] jd_s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
    end else begin
      v_s0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    jd_s0 <= julian_day;
  end

  // ---------------- stage 1: days since epoch times the three rates
  logic [55:0]        n_full;
  logic signed [23:0] ni;
  logic [31:0]        nf;
  logic               v_s1;
  logic [31:0]        hini_s1 [3];
  logic [63:0]        loni_s1 [3];
  logic [63:0]        hinf_s1 [3];
  logic [31:0]        lonf_s1 [3];

  assign n_full = {2'b00, jd_s0} - J2000_FX;
  assign ni     = $signed(n_full[55:32]);
  assign nf     = n_full[31:0];

  // ---------------- stage 2: partial sums
  logic        v_s2;
  logic [63:0] a_s2 [3];
  logic [63:0] b_s2 [3];

  // ---------------- stage 3: angles in turns
  logic        v_s3;
  logic [31:0] ang_s3 [3];

  for (genvar k = 0; k < 3; k++) begin : g_ang
    logic signed [56:0] hini_p;
    logic signed [56:0] loni_p;
    logic [63:0]        hinf_p;
    logic [63:0]        lonf_p;
    logic [63:0]        t;

    assign hini_p = $signed({1'b0, RATE[k][63:32]}) * ni;
    assign loni_p = $signed({1'b0, RATE[k][31:0]}) * ni;
    assign hinf_p = {32'b0, RATE[k][63:32]} * {32'b0, nf};
    assign lonf_p = {32'b0, RATE[k][31:0]} * {32'b0, nf};

    if (k == 2) begin : g_sub
      assign t = OFF[k] - a_s2[k] - b_s2[k];
    end else begin : g_add
      assign t = OFF[k] + a_s2[k] + b_s2[k];
    end

    // hold products, sums and rounded angle
    always_ff @(posedge clk) begin
      hini_s1[k] <= hini_p[31:0];
      loni_s1[k] <= {{7{loni_p[56]}}, loni_p};
      hinf_s1[k] <= hinf_p;
      lonf_s1[k] <= lonf_p[63:32];
      a_s2[k]    <= {hini_s1[k], 32'b0} + loni_s1[k];
      b_s2[k]    <= hinf_s1[k] + {32'b0, lonf_s1[k]};
      ang_s3[k]  <= t[63:32] + {31'b0, t[31]};
    end
  end

  // ---------------- stage 4: sin/cos setup for g and 2g
  logic               v_s4;
  logic signed [63:0] pg_s4, p2g_s4;
  logic [1:0]         qg_s4, q2g_s4;
  logic [31:0]        l_s4, e_s4;
  logic [31:0]        g2;

  assign g2 = {ang_s3[1][30:0], 1'b0};

  always_ff @(posedge clk) begin
    pg_s4  <= turn_residual(ang_s3[1]) * PI33;
    p2g_s4 <= turn_residual(g2) * PI33;
    qg_s4  <= turn_quadrant(ang_s3[1]);
    q2g_s4 <= turn_quadrant(g2);
    l_s4   <= ang_s3[0];
    e_s4   <= ang_s3[2];
  end

  logic                va, vb;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic [65:0]          ma;
  logic [1:0]           mb;

  srd_cordic #(.W(CW), .STEPS(NSTEP), .MW(66), .VECTORING(1'b0)) u_cordic_g (
    .clk, .rst,
    .in_valid (v_s4), .in_x (GAIN_Q30), .in_y ('0), .in_z (z_start(pg_s4)),
    .in_meta  ({qg_s4, l_s4, e_s4}),
    .out_valid(va), .out_x (ax), .out_y (ay), .out_z (), .out_meta (ma)
  );

  srd_cordic #(.W(CW), .STEPS(NSTEP), .MW(2), .VECTORING(1'b0)) u_cordic_2g (
    .clk, .rst,
    .in_valid (v_s4), .in_x (GAIN_Q30), .in_y ('0), .in_z (z_start(p2g_s4)),
    .in_meta  (q2g_s4),
    .out_valid(vb), .out_x (bx), .out_y (by), .out_z (), .out_meta (mb)
  );

  // ---------------- stage 5: equation-of-center products
  logic               v_s5;
  logic signed [63:0] p1_s5, p2_s5;
  logic [31:0]        l_s5, e_s5;
  sc_t                sc_g, sc_2g;

  assign sc_g  = quad_fold(ma[65:64], ax, ay);
  assign sc_2g = quad_fold(mb, bx, by);

  always_ff @(posedge clk) begin
    p1_s5 <= $signed({1'b0, A1_TURN}) * sc_g.si;
    p2_s5 <= $signed({1'b0, A2_TURN}) * sc_2g.si;
    l_s5  <= ma[63:32];
    e_s5  <= ma[31:0];
  end

  // ---------------- stage 6: ecliptic longitude
  logic               v_s6;
  logic [31:0]        lam_s6, e_s6;
  logic signed [63:0] r1, r2;

  assign r1 = rnd30(p1_s5);
  assign r2 = rnd30(p2_s5);

  always_ff @(posedge clk) begin
    lam_s6 <= l_s5 + r1[31:0] + r2[31:0];
    e_s6   <= e_s5;
  end

  // ---------------- stage 7: sin/cos setup for lambda and epsilon
  logic               v_s7;
  logic signed [63:0] pl_s7, pe_s7;
  logic [1:0]         ql_s7, qe_s7;

  always_ff @(posedge clk) begin
    pl_s7 <= turn_residual(lam_s6) * PI33;
    pe_s7 <= turn_residual(e_s6) * PI33;
    ql_s7 <= turn_quadrant(lam_s6);
    qe_s7 <= turn_quadrant(e_s6);
  end

  logic                 vc, vd;
  logic signed [CW-1:0] cx, cy, dx, dy;
  logic [1:0]           mc, md;

  srd_cordic #(.W(CW), .STEPS(NSTEP), .MW(2), .VECTORING(1'b0)) u_cordic_lam (
    .clk, .rst,
    .in_valid (v_s7), .in_x (GAIN_Q30), .in_y ('0), .in_z (z_start(pl_s7)),
    .in_meta  (ql_s7),
    .out_valid(vc), .out_x (cx), .out_y (cy), .out_z (), .out_meta (mc)
  );

  srd_cordic #(.W(CW), .STEPS(NSTEP), .MW(2), .VECTORING(1'b0)) u_cordic_eps (
    .clk, .rst,
    .in_valid (v_s7), .in_x (GAIN_Q30), .in_y ('0), .in_z (z_start(pe_s7)),
    .in_meta  (qe_s7),
    .out_valid(vd), .out_x (dx), .out_y (dy), .out_z (), .out_meta (md)
  );

  // ---------------- stage 8: rotate into equatorial frame
  logic               v_s8;
  logic signed [63:0] pra_s8, pde_s8;
  logic signed [31:0] cl_s8;
  sc_t                sc_l, sc_e;

  assign sc_l = quad_fold(mc, cx, cy);
  assign sc_e = quad_fold(md, dx, dy);

  always_ff @(posedge clk) begin
    pra_s8 <= sc_e.co * sc_l.si;
    pde_s8 <= sc_e.si * sc_l.si;
    cl_s8  <= sc_l.co;
  end

  // ---------------- stage 9: round products, clamp sine of declination
  logic               v_s9;
  logic signed [31:0] yra_s9, s_s9, cl_s9;
  logic signed [63:0] yra_r, sd_r, sd_c;

  assign yra_r = rnd30(pra_s8);
  assign sd_r  = rnd30(pde_s8);

  always_comb begin
    sd_c = sd_r;
    if (sd_r > 64'sd1073741824) sd_c = 64'sd1073741824;
    if (sd_r < -64'sd1073741824) sd_c = -64'sd1073741824;
  end

  always_ff @(posedge clk) begin
    yra_s9 <= yra_r[31:0];
    s_s9   <= sd_c[31:0];
    cl_s9  <= cl_s8;
  end

  // ---------------- stage 10: square of the sine
  logic               v_s10;
  logic signed [63:0] sq_s10;
  logic signed [31:0] s_s10, yra_s10, cl_s10;

  always_ff @(posedge clk) begin
    sq_s10  <= s_s9 * s_s9;
    s_s10   <= s_s9;
    yra_s10 <= yra_s9;
    cl_s10  <= cl_s9;
  end

  // ---------------- square root of 1 - s^2
  logic [62:0]        rt_rem  [1:32];
  logic [62:0]        rt_root [1:32];
  logic signed [31:0] rt_s    [1:32];
  logic signed [31:0] rt_y    [1:32];
  logic signed [31:0] rt_x    [1:32];
  logic               rt_v    [1:32];
  logic [63:0]        rad;

  assign rad = 64'h1000_0000_0000_0000 - sq_s10;

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * j);
    logic [62:0]        rem_c, root_c, trial;
    logic signed [31:0] s_c, y_c, x_c;
    logic               v_c, take;

    if (j == 0) begin : g_first
      assign rem_c  = rad[62:0];
      assign root_c = '0;
      assign s_c    = s_s10;
      assign y_c    = yra_s10;
      assign x_c    = cl_s10;
      assign v_c    = v_s10;
    end else begin : g_next
      assign rem_c  = rt_rem[j];
      assign root_c = rt_root[j];
      assign s_c    = rt_s[j];
      assign y_c    = rt_y[j];
      assign x_c    = rt_x[j];
      assign v_c    = rt_v[j];
    end

    assign trial = root_c + BIT;
    assign take  = rem_c >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[j+1] <= 1'b0;
      end else begin
        rt_v[j+1] <= v_c;
      end
    end

    // restore or subtract the trial value
    always_ff @(posedge clk) begin
      rt_rem[j+1]  <= take ? rem_c - trial : rem_c;
      rt_root[j+1] <= take ? (root_c >> 1) + BIT : (root_c >> 1);
      rt_s[j+1]    <= s_c;
      rt_y[j+1]    <= y_c;
      rt_x[j+1]    <= x_c;
    end
  end

  // ---------------- stage 12: atan2 setup for both angles
  logic v_s12;
  at2_t at_ra_s12, at_de_s12;

  always_ff @(posedge clk) begin
    at_ra_s12 <= at2_prep(CW'(rt_y[32]), CW'(rt_x[32]));
    at_de_s12 <= at2_prep(CW'(rt_s[32]), $signed({1'b0, rt_root[32][CW-2:0]}));
  end

  logic                 ve, vf;
  logic signed [CW-1:0] ez, fz;
  logic [CW:0]          me, mf;

  srd_cordic #(.W(CW), .STEPS(NSTEP), .MW(CW + 1), .VECTORING(1'b1)) u_cordic_ra (
    .clk, .rst,
    .in_valid (v_s12), .in_x (at_ra_s12.x), .in_y (at_ra_s12.y), .in_z ('0),
    .in_meta  ({at_ra_s12.zero, at_ra_s12.base}),
    .out_valid(ve), .out_x (), .out_y (), .out_z (ez), .out_meta (me)
  );

  srd_cordic #(.W(CW), .STEPS(NSTEP), .MW(CW + 1), .VECTORING(1'b1)) u_cordic_dec (
    .clk, .rst,
    .in_valid (v_s12), .in_x (at_de_s12.x), .in_y (at_de_s12.y), .in_z ('0),
    .in_meta  ({at_de_s12.zero, at_de_s12.base}),
    .out_valid(vf), .out_x (), .out_y (), .out_z (fz), .out_meta (mf)
  );

  // ---------------- output register
  always_ff @(posedge clk) begin
    right_ascension <= out_angle(me[CW], $signed(me[CW-1:0]), ez);
    declination     <= out_angle(mf[CW], $signed(mf[CW-1:0]), fz);
  end

  // advance valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1  <= 1'b0;
      v_s2  <= 1'b0;
      v_s3  <= 1'b0;
      v_s4  <= 1'b0;
      v_s5  <= 1'b0;
      v_s6  <= 1'b0;
      v_s7  <= 1'b0;
      v_s8  <= 1'b0;
      v_s9  <= 1'b0;
      v_s10 <= 1'b0;
      v_s12 <= 1'b0;
      done  <= 1'b0;
    end else begin
      v_s1  <= v_s0;
      v_s2  <= v_s1;
      v_s3  <= v_s2;
      v_s4  <= v_s3;
      v_s5  <= va;
      v_s6  <= v_s5;
      v_s7  <= v_s6;
      v_s8  <= vc;
      v_s9  <= v_s8;
      v_s10 <= v_s9;
      v_s12 <= rt_v[32];
      done  <= ve;
    end
  end

  // ---------------- checks
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (va == vb) && (vc == vd) && (ve == vf))
    else $error("parallel CORDIC lanes out of step");

  // each taken beat must show up as a done pulse at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LAT + 1) done)
    else $error("result beat missing at fixed latency");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (right_ascension <= OUT_LIMIT) && (right_ascension >= -OUT_LIMIT) &&
             (declination <= OUT_LIMIT) && (declination >= -OUT_LIMIT))
    else $error("result outside saturation limits");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v_s12, NSTEP + 1))
    else $error("result beat without an item behind it");

endmodule

`default_nettype wire
